// File: rtl/core/tam_pkg.sv
// Shared types and constants for the three-axis acceleration magnitude pipeline.
// Depends on nothing; every core module refers to it by scoped names.
`timescale 1ns / 1ps
`default_nettype none

package tam_pkg;

    localparam int RAW_W      = 14;
    localparam int SLOT_W     = 7;
    localparam int MAG_W      = 12;
    localparam int QTR_W      = 11;
    localparam int SQR_W      = 2 * QTR_W;
    localparam int SUM_W      = 24;
    localparam int REM_W      = MAG_W + 1;
    localparam int SLOTS_DEF  = 128;
    localparam int SQ_STAGES  = 4;
    localparam int SQ_STEPS   = 3;
    localparam logic [MAG_W-1:0] MAG_MAX = 12'd3545;

    typedef struct packed {
        logic [RAW_W-1:0]  raw_x;
        logic [RAW_W-1:0]  raw_y;
        logic [RAW_W-1:0]  raw_z;
        logic [SLOT_W-1:0] sample_slot;
    } t_in;

    typedef struct packed {
        logic [MAG_W-1:0]  magnitude;
        logic [SLOT_W-1:0] result_slot;
    } t_out;

    typedef struct packed {
        logic [QTR_W-1:0]  qx;
        logic [QTR_W-1:0]  qy;
        logic [QTR_W-1:0]  qz;
        logic [SLOT_W-1:0] slot;
    } t_quarter;

    typedef struct packed {
        logic [SUM_W-1:0]  v;
        logic [REM_W-1:0]  rem;
        logic [MAG_W-1:0]  root;
        logic [SLOT_W-1:0] slot;
    } t_root_state;

endpackage

`default_nettype wire

// File: rtl/core/tam_front.sv
// Front stage: per-axis magnitude, quarter scaling and slot saturation.
// Depends on tam_pkg for the item and stage types.
`timescale 1ns / 1ps
`default_nettype none

module tam_front #(
    parameter int SLOTS = tam_pkg::SLOTS_DEF
) (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_valid,
    input  tam_pkg::t_in     i_data,
    output logic             o_stall,
    output logic             o_valid,
    output tam_pkg::t_quarter o_data,
    input  wire              i_stall
);

    logic              r_valid;
    tam_pkg::t_quarter r_data;
    tam_pkg::t_quarter n_data;

    function automatic logic [tam_pkg::QTR_W-1:0] quarter(
        input logic [tam_pkg::RAW_W-1:0] w
    );
        logic [tam_pkg::RAW_W-1:0] m;
        begin
            m = w[tam_pkg::RAW_W-1] ? (tam_pkg::RAW_W'(0) - w) : w;
            quarter = m[tam_pkg::RAW_W-2:2];
        end
    endfunction

    always_comb begin
        n_data.qx = quarter(i_data.raw_x);
        n_data.qy = quarter(i_data.raw_y);
        n_data.qz = quarter(i_data.raw_z);
        if ({25'd0, i_data.sample_slot} >= 32'(SLOTS)) begin
            n_data.slot = tam_pkg::SLOT_W'(SLOTS - 1);
        end else begin
            n_data.slot = i_data.sample_slot;
        end
    end

    assign o_stall = r_valid & i_stall;
    assign o_valid = r_valid;
    assign o_data  = r_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (!o_stall) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_stall) begin
            r_data <= n_data;
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/tam_square_sum.sv
// Two stages: three 11x11 squares, then their 24-bit sum seeded as root state.
// Depends on tam_pkg for the stage types.
`timescale 1ns / 1ps
`default_nettype none

module tam_square_sum (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_valid,
    input  tam_pkg::t_quarter   i_data,
    output logic                o_stall,
    output logic                o_valid,
    output tam_pkg::t_root_state o_data,
    input  wire                 i_stall
);

    logic                      r_sq_valid;
    logic [tam_pkg::SQR_W-1:0] r_sx;
    logic [tam_pkg::SQR_W-1:0] r_sy;
    logic [tam_pkg::SQR_W-1:0] r_sz;
    logic [tam_pkg::SLOT_W-1:0] r_sq_slot;
    logic                      sq_stall;

    logic                 r_valid;
    tam_pkg::t_root_state r_data;
    tam_pkg::t_root_state n_data;

    assign o_stall  = r_sq_valid & sq_stall;
    assign sq_stall = r_valid & i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sq_valid <= 1'b0;
        end else if (!o_stall) begin
            r_sq_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_stall) begin
            r_sx      <= tam_pkg::SQR_W'(i_data.qx) * tam_pkg::SQR_W'(i_data.qx);
            r_sy      <= tam_pkg::SQR_W'(i_data.qy) * tam_pkg::SQR_W'(i_data.qy);
            r_sz      <= tam_pkg::SQR_W'(i_data.qz) * tam_pkg::SQR_W'(i_data.qz);
            r_sq_slot <= i_data.slot;
        end
    end

    always_comb begin
        n_data.v    = tam_pkg::SUM_W'(r_sx) + tam_pkg::SUM_W'(r_sy) + tam_pkg::SUM_W'(r_sz);
        n_data.rem  = '0;
        n_data.root = '0;
        n_data.slot = r_sq_slot;
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (!sq_stall) begin
            r_valid <= r_sq_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!sq_stall) begin
            r_data <= n_data;
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/tam_sqrt_stage.sv
// One square-root stage: a fixed number of two-bit digit steps, registered.
// Depends on tam_pkg for the root state type and step count.
`timescale 1ns / 1ps
`default_nettype none

module tam_sqrt_stage (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_valid,
    input  tam_pkg::t_root_state i_data,
    output logic                 o_stall,
    output logic                 o_valid,
    output tam_pkg::t_root_state o_data,
    input  wire                  i_stall
);

    logic                 r_valid;
    tam_pkg::t_root_state r_data;
    tam_pkg::t_root_state n_data;

    always_comb begin
        logic [tam_pkg::REM_W+1:0] acc;
        logic [tam_pkg::REM_W+1:0] trial;
        n_data = i_data;
        for (int k = 0; k < tam_pkg::SQ_STEPS; k++) begin
            acc   = {n_data.rem, n_data.v[tam_pkg::SUM_W-1 -: 2]};
            trial = {1'b0, n_data.root, 2'b01};
            n_data.v = {n_data.v[tam_pkg::SUM_W-3:0], 2'b00};
            if (acc >= trial) begin
                n_data.rem  = tam_pkg::REM_W'(acc - trial);
                n_data.root = {n_data.root[tam_pkg::MAG_W-2:0], 1'b1};
            end else begin
                n_data.rem  = tam_pkg::REM_W'(acc);
                n_data.root = {n_data.root[tam_pkg::MAG_W-2:0], 1'b0};
            end
        end
    end

    assign o_stall = r_valid & i_stall;
    assign o_valid = r_valid;
    assign o_data  = r_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (!o_stall) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_stall) begin
            r_data <= n_data;
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/three_axis_accel_magnitude.sv
// An accepted item passes the front register, the square and sum registers, then the square-root stages.
// One item per cycle while i_stall is low; each of the 7 register stages holds one item.
// The square root runs as 4 stages of 3 two-bit digit steps, which sets the depth.
// Reset clears every stage valid bit; payload registers are not reset.
// Depends on tam_pkg, tam_front, tam_square_sum and tam_sqrt_stage.
`timescale 1ns / 1ps
`default_nettype none

module three_axis_accel_magnitude #(
    parameter int SLOTS = tam_pkg::SLOTS_DEF
) (
    input  wire           i_clk,
    input  wire           i_rst_n,
    input  wire           i_valid,
    input  tam_pkg::t_in  i_item,
    output logic          o_stall,
    output logic          o_valid,
    output tam_pkg::t_out o_result,
    input  wire           i_stall
);

    logic              fr_valid;
    logic              fr_stall;
    tam_pkg::t_quarter fr_data;

    logic                 sq_valid [0:tam_pkg::SQ_STAGES];
    logic                 sq_stall [0:tam_pkg::SQ_STAGES];
    tam_pkg::t_root_state sq_data  [0:tam_pkg::SQ_STAGES];

    tam_front #(
        .SLOTS (SLOTS)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_data  (i_item),
        .o_stall (o_stall),
        .o_valid (fr_valid),
        .o_data  (fr_data),
        .i_stall (fr_stall)
    );

    tam_square_sum u_square_sum (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (fr_valid),
        .i_data  (fr_data),
        .o_stall (fr_stall),
        .o_valid (sq_valid[0]),
        .o_data  (sq_data[0]),
        .i_stall (sq_stall[0])
    );

    for (genvar g = 0; g < tam_pkg::SQ_STAGES; g++) begin : g_sqrt
        tam_sqrt_stage u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (sq_valid[g]),
            .i_data  (sq_data[g]),
            .o_stall (sq_stall[g]),
            .o_valid (sq_valid[g+1]),
            .o_data  (sq_data[g+1]),
            .i_stall (sq_stall[g+1])
        );
    end

    assign sq_stall[tam_pkg::SQ_STAGES] = i_stall;
    assign o_valid              = sq_valid[tam_pkg::SQ_STAGES];
    assign o_result.magnitude   = sq_data[tam_pkg::SQ_STAGES].root;
    assign o_result.result_slot = sq_data[tam_pkg::SQ_STAGES].slot;

`ifndef SYNTH
    a_stall_full : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (o_valid && i_stall))
        else $error("input stalled while output stage can advance");

    a_mag_range : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_result.magnitude <= tam_pkg::MAG_MAX))
        else $error("magnitude out of range");

    a_slot_range : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ({25'd0, o_result.result_slot} < 32'(SLOTS)))
        else $error("result slot beyond buffer");
`endif

endmodule

`default_nettype wire
